/* rtl/setpoint_hold_extrapolator_unit_defines.svh */
// assertion macros for the setpoint hold extrapolator
`ifndef SETPOINT_HOLD_EXTRAPOLATOR_UNIT_DEFINES_SVH
`define SETPOINT_HOLD_EXTRAPOLATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SHE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SHE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/she_pkg.sv */
// shared types and constants for the setpoint hold extrapolator
package she_pkg;

	localparam int AXES = 3;

	// opcodes of an input transfer
	localparam logic [1:0] OP_SET   = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// hold modes
	localparam logic [1:0] MODE_ZOH = 2'd0;
	localparam logic [1:0] MODE_FOH = 2'd1;
	localparam logic [1:0] MODE_SOH = 2'd2;
	localparam logic [1:0] MODE_OVR = 2'd3;

	// divider: two quotient bits per cycle over a 66-bit dividend
	localparam int DIV_W   = 66;
	localparam int DIV_CYC = DIV_W / 2;
	localparam int MAC_STEPS = 8;

	localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
	localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_VSTART,
		S_VWAIT,
		S_ASTART,
		S_AWAIT,
		S_MAC,
		S_DRAIN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic        set_en;
		logic        shift_prev;
		logic        clr;
		logic        div_start;
		logic        div_acc;
		logic        q_load;
		logic        mac_en;
		logic [2:0]  mac_step;
		logic        ovr;
		logic        dneg;
		logic [31:0] udt;
		logic [63:0] udt2;
	} lane_ctrl_t;

	typedef struct packed {
		logic signed [31:0] pos;
		logic signed [47:0] vel;
		logic signed [47:0] acc;
	} lane_res_t;

endpackage

/* rtl/she_in_if.sv */
// setpoint and query input channel
interface she_in_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  opcode;
	logic        [31:0] stamp_time;
	logic signed [31:0] set_x;
	logic signed [31:0] set_y;
	logic signed [31:0] set_z;

	modport source (output valid, output opcode, output stamp_time,
		output set_x, output set_y, output set_z, input ready);
	modport sink (input valid, input opcode, input stamp_time,
		input set_x, input set_y, input set_z, output ready);
endinterface

/* rtl/she_out_if.sv */
// extrapolated result output channel
interface she_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [47:0] vel_x;
	logic signed [47:0] vel_y;
	logic signed [47:0] vel_z;
	logic signed [47:0] acc_x;
	logic signed [47:0] acc_y;
	logic signed [47:0] acc_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output vel_x, output vel_y, output vel_z,
		output acc_x, output acc_y, output acc_z, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z,
		input vel_x, input vel_y, input vel_z,
		input acc_x, input acc_y, input acc_z, output ready);
endinterface

/* rtl/she_div.sv */
// radix-4 restoring divider: num * 2^16 / den, truncated, saturated to 48 bits
module she_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [48:0] num,
	input  logic        [31:0] den,
	output logic               done,
	output logic signed [47:0] quo
);
	import she_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic [31:0]       rem_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  quo_q;
	logic              neg_q;
	logic [48:0]       mag;
	logic [32:0]       t1;
	logic [32:0]       t2;
	logic [31:0]       r1;
	logic [31:0]       r2;
	logic              ge1;
	logic              ge2;
	logic              big;

	assign mag = num[48] ? 49'(-num) : num;

	// two restoring steps per cycle
	always_comb begin
		t1  = {rem_q, dvd_q[DIV_W-1]};
		ge1 = t1 >= {1'b0, den};
		r1  = ge1 ? 32'(t1 - {1'b0, den}) : t1[31:0];
		t2  = {r1, dvd_q[DIV_W-2]};
		ge2 = t2 >= {1'b0, den};
		r2  = ge2 ? 32'(t2 - {1'b0, den}) : t2[31:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_CYC);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[48];
			dvd_q <= {1'b0, mag, 16'b0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-3:0], 2'b00};
			rem_q <= r2;
			quo_q <= {quo_q[DIV_W-3:0], ge1, ge2};
		end
	end

	// sign and saturation
	assign big  = |quo_q[DIV_W-1:47];
	assign done = done_q;
	always_comb begin
		if (big)
			quo = neg_q ? MIN48 : MAX48;
		else
			quo = neg_q ? 48'(-quo_q[47:0]) : quo_q[47:0];
	end

endmodule

/* rtl/she_lane.sv */
// one axis lane: held samples, derivative divider and query multiply-accumulate
module she_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  she_pkg::lane_ctrl_t   ctrl,
	input  logic signed [31:0]    set_pos,
	output logic                  div_done,
	output she_pkg::lane_res_t    res
);
	import she_pkg::*;

	logic signed [31:0]  cur_pos_q;
	logic signed [47:0]  cur_vel_q;
	logic signed [47:0]  cur_acc_q;
	logic signed [31:0]  prev_pos_q;
	logic signed [47:0]  prev_vel_q;
	logic signed [48:0]  div_num;
	logic signed [47:0]  div_q;
	logic [47:0]         vel_mag;
	logic [47:0]         acc_mag;
	logic [47:0]         op_a;
	logic [15:0]         chunk;
	logic [1:0]          sh;
	logic                neg;
	logic                to_v;
	logic [63:0]         prod;
	logic [63:0]         prod_s1;
	logic                valid_s1;
	logic [1:0]          sh_s1;
	logic                neg_s1;
	logic                to_v_s1;
	logic [113:0]        sp;
	logic signed [113:0] accp_q;
	logic signed [81:0]  accv_q;
	logic signed [81:0]  pfl;
	logic signed [65:0]  vfl;
	logic signed [31:0]  sat_p;
	logic signed [47:0]  sat_v;

	// numerator of the velocity or acceleration estimate
	always_comb begin
		if (ctrl.div_acc)
			div_num = {cur_vel_q[47], cur_vel_q} - {prev_vel_q[47], prev_vel_q};
		else
			div_num = {{17{cur_pos_q[31]}}, cur_pos_q} - {{17{prev_pos_q[31]}}, prev_pos_q};
	end

	she_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.div_start),
		.num    (div_num),
		.den    (ctrl.udt),
		.done   (div_done),
		.quo    (div_q)
	);

	// held samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pos_q  <= '0;
			cur_vel_q  <= '0;
			cur_acc_q  <= '0;
			prev_pos_q <= '0;
			prev_vel_q <= '0;
		end else if (ctrl.clr) begin
			cur_pos_q  <= '0;
			cur_vel_q  <= '0;
			cur_acc_q  <= '0;
			prev_pos_q <= '0;
			prev_vel_q <= '0;
		end else if (ctrl.set_en) begin
			if (ctrl.shift_prev) begin
				prev_pos_q <= cur_pos_q;
				prev_vel_q <= cur_vel_q;
			end
			cur_pos_q <= set_pos;
			cur_vel_q <= '0;
			cur_acc_q <= '0;
		end else if (div_done) begin
			if (ctrl.div_acc)
				cur_acc_q <= div_q;
			else
				cur_vel_q <= div_q;
		end
	end

	assign vel_mag = cur_vel_q[47] ? 48'(-cur_vel_q) : cur_vel_q;
	assign acc_mag = cur_acc_q[47] ? 48'(-cur_acc_q) : cur_acc_q;

	// partial product schedule: v*dt, a*dt^2 into position, a*dt into velocity
	always_comb begin
		unique case (ctrl.mac_step)
			3'd0: begin
				op_a = vel_mag; chunk = ctrl.udt[15:0]; sh = 2'd1;
				neg = cur_vel_q[47] ^ ctrl.dneg; to_v = 1'b0;
			end
			3'd1: begin
				op_a = vel_mag; chunk = ctrl.udt[31:16]; sh = 2'd2;
				neg = cur_vel_q[47] ^ ctrl.dneg; to_v = 1'b0;
			end
			3'd2: begin
				op_a = acc_mag; chunk = ctrl.udt2[15:0]; sh = 2'd0;
				neg = cur_acc_q[47]; to_v = 1'b0;
			end
			3'd3: begin
				op_a = acc_mag; chunk = ctrl.udt2[31:16]; sh = 2'd1;
				neg = cur_acc_q[47]; to_v = 1'b0;
			end
			3'd4: begin
				op_a = acc_mag; chunk = ctrl.udt2[47:32]; sh = 2'd2;
				neg = cur_acc_q[47]; to_v = 1'b0;
			end
			3'd5: begin
				op_a = acc_mag; chunk = ctrl.udt2[63:48]; sh = 2'd3;
				neg = cur_acc_q[47]; to_v = 1'b0;
			end
			3'd6: begin
				op_a = acc_mag; chunk = ctrl.udt[15:0]; sh = 2'd0;
				neg = cur_acc_q[47] ^ ctrl.dneg; to_v = 1'b1;
			end
			default: begin
				op_a = acc_mag; chunk = ctrl.udt[31:16]; sh = 2'd1;
				neg = cur_acc_q[47] ^ ctrl.dneg; to_v = 1'b1;
			end
		endcase
	end

	assign prod = op_a * chunk;

	// product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= ctrl.mac_en;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		sh_s1   <= sh;
		neg_s1  <= neg;
		to_v_s1 <= to_v;
	end

	assign sp = {50'b0, prod_s1} << {sh_s1, 4'b0000};

	// accumulators
	always_ff @(posedge clk) begin
		if (ctrl.q_load) begin
			accp_q <= {{50{cur_pos_q[31]}}, cur_pos_q, 32'b0};
			accv_q <= {{18{cur_vel_q[47]}}, cur_vel_q, 16'b0};
		end else if (valid_s1) begin
			if (to_v_s1)
				accv_q <= neg_s1 ? accv_q - sp[81:0] : accv_q + sp[81:0];
			else
				accp_q <= neg_s1 ? accp_q - sp : accp_q + sp;
		end
	end

	// floor to the output format and saturate
	assign pfl = accp_q[113:32];
	assign vfl = accv_q[81:16];

	always_comb begin
		if (pfl[81:31] == {51{pfl[81]}})
			sat_p = pfl[31:0];
		else
			sat_p = pfl[81] ? MIN32 : MAX32;
		if (vfl[65:47] == {19{vfl[65]}})
			sat_v = vfl[47:0];
		else
			sat_v = vfl[65] ? MIN48 : MAX48;
	end

	assign res.pos = ctrl.ovr ? cur_pos_q : sat_p;
	assign res.vel = ctrl.ovr ? cur_vel_q : sat_v;
	assign res.acc = cur_acc_q;

endmodule

/* rtl/setpoint_hold_extrapolator_unit.sv */
// Setpoint hold extrapolator, top level. Takes time-stamped 3-axis setpoints and
// queries one transfer at a time; three axis lanes work side by side and a result
// register merges their outputs. A zero-order or override set, a reset and an
// unused opcode are handled in the idle state. A first-order set runs one divider
// pass and a second-order set two: each derivative runs through a radix-4 divider
// in every lane, velocity first, then acceleration. A query runs eight 48x16
// multiply-accumulate steps per lane plus load and drain; an override query
// skips them. The next transfer is accepted while a result still waits in the
// output register.
module setpoint_hold_extrapolator_unit (
	input  logic       clk,
	input  logic       arst_n,
	she_in_if.sink     setpt,
	she_out_if.source  result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata
);
	import she_pkg::*;

	`include "setpoint_hold_extrapolator_unit_defines.svh"

	state_t               state_q;
	state_t               state_d;
	logic [1:0]           mode_q;
	logic [31:0]          cur_time_q;
	logic [31:0]          prev_time_q;
	logic [31:0]          gap_q;
	logic [31:0]          udt_q;
	logic [63:0]          udt2_q;
	logic                 dneg_q;
	logic [2:0]           cnt_q;
	logic                 in_xfer;
	logic                 out_free;
	logic                 later;
	logic [31:0]          new_prev;
	logic                 do_div;
	logic [32:0]          dt;
	logic                 all_done;
	lane_ctrl_t           ctrl;
	lane_res_t            res [AXES];
	logic [AXES-1:0]      lane_done;
	logic signed [31:0]   set_pos [AXES];
	logic                 out_valid_q;
	lane_res_t            out_q [AXES];

	assign in_xfer  = setpt.valid && setpt.ready;
	assign out_free = !out_valid_q || result.ready;
	assign later    = setpt.stamp_time > cur_time_q;
	assign new_prev = later ? cur_time_q : prev_time_q;
	assign do_div   = ((mode_q == MODE_FOH) || (mode_q == MODE_SOH))
		&& (setpt.stamp_time > new_prev);
	assign dt       = {1'b0, setpt.stamp_time} - {1'b0, cur_time_q};
	assign all_done = &lane_done;

	assign set_pos[0] = setpt.set_x;
	assign set_pos[1] = setpt.set_y;
	assign set_pos[2] = setpt.set_z;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if (setpt.opcode == OP_SET && do_div)
						state_d = S_VSTART;
					else if (setpt.opcode == OP_QUERY)
						state_d = (mode_q == MODE_OVR) ? S_EMIT : S_MAC;
				end
			end
			S_VSTART: state_d = S_VWAIT;
			S_VWAIT: begin
				if (all_done)
					state_d = (mode_q == MODE_SOH) ? S_ASTART : S_IDLE;
			end
			S_ASTART: state_d = S_AWAIT;
			S_AWAIT: begin
				if (all_done)
					state_d = S_IDLE;
			end
			S_MAC: begin
				if (cnt_q == 3'(MAC_STEPS - 1))
					state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// lane controls and handshake outputs
	always_comb begin
		setpt.ready     = (state_q == S_IDLE);
		ctrl.set_en     = in_xfer && (setpt.opcode == OP_SET);
		ctrl.shift_prev = later;
		ctrl.clr        = in_xfer && (setpt.opcode == OP_CLEAR);
		ctrl.q_load     = in_xfer && (setpt.opcode == OP_QUERY);
		ctrl.div_start  = (state_q == S_VSTART) || (state_q == S_ASTART);
		ctrl.div_acc    = (state_q == S_ASTART) || (state_q == S_AWAIT);
		ctrl.mac_en     = (state_q == S_MAC);
		ctrl.mac_step   = cnt_q;
		ctrl.ovr        = (mode_q == MODE_OVR);
		ctrl.dneg       = dneg_q;
		ctrl.udt        = ctrl.div_acc || (state_q == S_VSTART) || (state_q == S_VWAIT)
			? gap_q : udt_q;
		ctrl.udt2       = udt2_q;
	end

	// axis lanes
	for (genvar i = 0; i < AXES; i++) begin : g_lane
		she_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.set_pos  (set_pos[i]),
			.div_done (lane_done[i]),
			.res      (res[i])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_FOH;
			cur_time_q  <= '0;
			prev_time_q <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				mode_q <= cfg_wdata;
			if (in_xfer && setpt.opcode == OP_SET) begin
				cur_time_q  <= setpt.stamp_time;
				prev_time_q <= new_prev;
			end else if (in_xfer && setpt.opcode == OP_CLEAR) begin
				cur_time_q  <= setpt.stamp_time;
				prev_time_q <= '0;
			end
			if (state_q == S_MAC)
				cnt_q <= cnt_q + 3'd1;
			else
				cnt_q <= '0;
			if (state_q == S_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	// time gap and query distance
	always_ff @(posedge clk) begin
		if (in_xfer && setpt.opcode == OP_SET)
			gap_q <= setpt.stamp_time - new_prev;
		if (in_xfer && setpt.opcode == OP_QUERY) begin
			dneg_q <= dt[32];
			udt_q  <= dt[32] ? 32'(-dt) : dt[31:0];
		end
		udt2_q <= udt_q * udt_q;
	end

	// merge lane results into the output register
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			for (int i = 0; i < AXES; i++)
				out_q[i] <= res[i];
		end
	end

	assign result.valid = out_valid_q;
	assign result.pos_x = out_q[0].pos;
	assign result.pos_y = out_q[1].pos;
	assign result.pos_z = out_q[2].pos;
	assign result.vel_x = out_q[0].vel;
	assign result.vel_y = out_q[1].vel;
	assign result.vel_z = out_q[2].vel;
	assign result.acc_x = out_q[0].acc;
	assign result.acc_y = out_q[1].acc;
	assign result.acc_z = out_q[2].acc;

	// checks
	`SHE_ASSERT_NOW(a_lanes_agree, lane_done != '0, all_done, "lane dividers out of step")
	`SHE_ASSERT_NOW(a_out_from_emit, $rose(out_valid_q), $past(state_q) == S_EMIT, "result without query")
	`SHE_ASSERT_NEXT(a_zoh_set_fast, in_xfer && setpt.opcode == OP_SET && mode_q == MODE_ZOH, setpt.ready, "zero-order set not done in one cycle")

endmodule

/* tb/sv/she_result_checker.sv */
// result checker: predicts every query result and compares it with the block output
`timescale 1ns / 100ps
module she_result_checker (
	input  logic       clk,
	input  logic       arst_n,
	she_in_if          in_ch,
	she_out_if         out_ch,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	output int         fails,
	output int         pending
);
	import she_pkg::*;

	typedef struct {
		logic signed [31:0] pos [AXES];
		logic signed [47:0] vel [AXES];
		logic signed [47:0] acc [AXES];
	} motion_t;

	motion_t result_q [$];

	// predicted block state
	logic [1:0]         mode;
	logic [31:0]        cur_t, prev_t;
	logic signed [31:0] cur_p [AXES];
	logic signed [31:0] prev_p [AXES];
	logic signed [47:0] cur_v [AXES];
	logic signed [47:0] prev_v [AXES];
	logic signed [47:0] cur_a [AXES];

	assign pending = result_q.size();

	// num * 2^16 / den, truncated toward zero, saturated to 48 bits
	function automatic logic signed [47:0] rate_q16(logic signed [127:0] num, logic [31:0] den);
		logic [127:0] mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag << 16) / {96'd0, den};
		if (num < 0)
			return (q >= (128'd1 << 47)) ? MIN48 : -q[47:0];
		return (q > 128'h7FFF_FFFF_FFFF) ? MAX48 : q[47:0];
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [127:0] w);
		logic signed [127:0] hi, lo;
		hi = MAX32;
		lo = MIN32;
		if (w > hi) return MAX32;
		if (w < lo) return MIN32;
		return w[31:0];
	endfunction

	function automatic logic signed [47:0] clamp48(logic signed [127:0] w);
		logic signed [127:0] hi, lo;
		hi = MAX48;
		lo = MIN48;
		if (w > hi) return MAX48;
		if (w < lo) return MIN48;
		return w[47:0];
	endfunction

	task automatic clear_motion(logic [31:0] t);
		cur_t = t;
		prev_t = '0;
		for (int i = 0; i < AXES; i++) begin
			cur_p[i] = '0; cur_v[i] = '0; cur_a[i] = '0;
			prev_p[i] = '0; prev_v[i] = '0;
		end
	endtask

	task automatic store_setpoint(logic [31:0] t, logic signed [31:0] sp [AXES]);
		logic [31:0] gap;
		if (t > cur_t) begin
			prev_t = cur_t;
			for (int i = 0; i < AXES; i++) begin
				prev_p[i] = cur_p[i];
				prev_v[i] = cur_v[i];
			end
		end
		cur_t = t;
		gap = t - prev_t;
		for (int i = 0; i < AXES; i++) begin
			cur_p[i] = sp[i];
			cur_v[i] = '0;
			cur_a[i] = '0;
			if ((mode == MODE_FOH || mode == MODE_SOH) && t > prev_t) begin
				cur_v[i] = rate_q16(128'(cur_p[i]) - 128'(prev_p[i]), gap);
				if (mode == MODE_SOH)
					cur_a[i] = rate_q16(128'(cur_v[i]) - 128'(prev_v[i]), gap);
			end
		end
	endtask

	function automatic motion_t extrapolate(logic [31:0] t);
		motion_t m;
		logic signed [127:0] dt, p, v, a, w;
		dt = $signed(128'(t)) - $signed(128'(cur_t));
		for (int i = 0; i < AXES; i++) begin
			p = cur_p[i];
			v = cur_v[i];
			a = cur_a[i];
			m.acc[i] = cur_a[i];
			if (mode == MODE_OVR) begin
				m.pos[i] = cur_p[i];
				m.vel[i] = cur_v[i];
			end else begin
				w = (p <<< 32) + ((v * dt) <<< 16) + a * dt * dt;
				m.pos[i] = clamp32(w >>> 32);
				w = (v <<< 16) + a * dt;
				m.vel[i] = clamp48(w >>> 16);
			end
		end
		return m;
	endfunction

	// track config, input transfers and output transfers
	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] sp [AXES];
		motion_t got, want;
		logic bad;
		if (!arst_n) begin
			mode = MODE_FOH;
			clear_motion('0);
			result_q.delete();
			fails = 0;
		end else begin
			if (cfg_we)
				mode = cfg_wdata;
			if (in_ch.valid && in_ch.ready) begin
				sp[0] = in_ch.set_x; sp[1] = in_ch.set_y; sp[2] = in_ch.set_z;
				case (in_ch.opcode)
					OP_SET: store_setpoint(in_ch.stamp_time, sp);
					OP_CLEAR: clear_motion(in_ch.stamp_time);
					OP_QUERY: result_q.push_back(extrapolate(in_ch.stamp_time));
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got.pos[0] = out_ch.pos_x; got.pos[1] = out_ch.pos_y; got.pos[2] = out_ch.pos_z;
				got.vel[0] = out_ch.vel_x; got.vel[1] = out_ch.vel_y; got.vel[2] = out_ch.vel_z;
				got.acc[0] = out_ch.acc_x; got.acc[1] = out_ch.acc_y; got.acc[2] = out_ch.acc_z;
				if (result_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result transfer pos %h %h %h", got.pos[0],
							got.pos[1], got.pos[2]);
				end else begin
					want = result_q.pop_front();
					bad = 1'b0;
					for (int i = 0; i < AXES; i++)
						if (got.pos[i] !== want.pos[i] || got.vel[i] !== want.vel[i] ||
								got.acc[i] !== want.acc[i])
							bad = 1'b1;
					if (bad) begin
						fails++;
						if (fails <= 10)
							for (int i = 0; i < AXES; i++)
								$display("axis %0d exp pos %h vel %h acc %h got pos %h vel %h acc %h",
									i, want.pos[i], want.vel[i], want.acc[i],
									got.pos[i], got.vel[i], got.acc[i]);
					end
				end
			end
		end
	end
endmodule

/* tb/sv/tb.sv */
// testbench top: stimulus, ready pressure, watchdog and verdict
`timescale 1ns / 100ps
module tb;
	import she_pkg::*;

	localparam int WATCH_LIMIT = 5000;
	localparam int SETTLE = 120;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;
	int         fails;
	int         pending;
	int         idle_cycles;
	logic       quiet;
	logic [31:0] t_now;

	she_in_if  setpt_ch ();
	she_out_if result_ch ();

	setpoint_hold_extrapolator_unit u_dut (
		.clk(clk), .arst_n(arst_n), .setpt(setpt_ch.sink), .result(result_ch.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	she_result_checker u_check (
		.clk(clk), .arst_n(arst_n), .in_ch(setpt_ch), .out_ch(result_ch),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .fails(fails), .pending(pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// idle length: mostly short, a few long, none in quiet stretches
	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(99);
		if (r < 45) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	// receiver stalls
	always @(negedge clk) begin
		if ($urandom_range(49) == 0) quiet <= ~quiet;
		result_ch.ready <= (quiet || pick_gap() == 0);
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((setpt_ch.valid && setpt_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("FAIL setpoint_hold_extrapolator_unit");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] op, logic [31:0] t, logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		int gap;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			setpt_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		setpt_ch.valid <= 1'b1;
		setpt_ch.opcode <= op;
		setpt_ch.stamp_time <= t;
		setpt_ch.set_x <= x;
		setpt_ch.set_y <= y;
		setpt_ch.set_z <= z;
		@(posedge clk);
		while (!setpt_ch.ready) @(posedge clk);
	endtask

	// wait for the block to drain, then write the hold mode
	task automatic write_mode(logic [1:0] m);
		@(negedge clk);
		setpt_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_pos();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return $urandom;
			2: return $urandom_range(1, 4);
			default: return $urandom_range(1, 32'h0004_0000);
		endcase
	endfunction

	task automatic random_phase(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 40) begin
				t_now = ($urandom_range(19) == 0) ? t_now - $urandom_range(0, 32'h0001_0000)
					: t_now + pick_step();
				send_item(OP_SET, t_now, pick_pos(), pick_pos(), pick_pos());
			end else if (r < 88) begin
				send_item(OP_QUERY, ($urandom_range(9) == 0) ? $urandom : t_now + pick_step()
					- 32'h0001_0000, $urandom, $urandom, $urandom);
			end else if (r < 94) begin
				t_now = ($urandom_range(1) == 0) ? $urandom : 32'd0;
				send_item(OP_CLEAR, t_now, $urandom, $urandom, $urandom);
			end else begin
				send_item(2'd3, $urandom, $urandom, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		logic [1:0] modes [8] = '{MODE_FOH, MODE_ZOH, MODE_SOH, MODE_OVR,
			MODE_SOH, MODE_FOH, MODE_ZOH, MODE_OVR};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet = 1'b0;
		idle_cycles = 0;
		t_now = '0;
		setpt_ch.valid = 1'b0;
		setpt_ch.opcode = OP_SET;
		setpt_ch.stamp_time = '0;
		setpt_ch.set_x = '0;
		setpt_ch.set_y = '0;
		setpt_ch.set_z = '0;
		result_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset-state query, extremes, equal and earlier times, unused opcode
		send_item(OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0);
		send_item(OP_SET, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		send_item(OP_SET, 32'h0001_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0);
		send_item(OP_QUERY, 32'h0000_0000, 0, 0, 0);
		send_item(OP_SET, 32'h0001_0001, 32'h0000_1000, 32'h0, 32'hFFFF_0000);
		send_item(OP_SET, 32'h0000_8000, 32'h0002_0000, 32'h1, 32'h0);
		send_item(OP_QUERY, 32'h0000_8000, 0, 0, 0);
		send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_CLEAR, 32'hFFFF_FFFF, 0, 0, 0);
		send_item(OP_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		send_item(OP_QUERY, 32'h0000_0000, 0, 0, 0);
		write_mode(MODE_SOH);
		send_item(OP_CLEAR, 32'h0, 0, 0, 0);
		send_item(OP_SET, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		send_item(OP_SET, 32'h0000_0002, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000);
		send_item(OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0);
		send_item(OP_QUERY, 32'h0000_0000, 0, 0, 0);
		write_mode(MODE_OVR);
		send_item(OP_QUERY, 32'h1234_0000, 0, 0, 0);
		write_mode(MODE_ZOH);
		send_item(OP_SET, 32'h0000_0003, 32'h0003_0000, 32'h0, 32'h0);
		send_item(OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0);
		t_now = 32'h0000_0003;

		// random phases through every hold mode
		foreach (modes[k]) begin
			write_mode(modes[k]);
			random_phase(172);
		end

		@(negedge clk);
		setpt_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (fails == 0)
			$display("PASS setpoint_hold_extrapolator_unit");
		else
			$display("FAIL setpoint_hold_extrapolator_unit");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/she_pkg.sv
rtl/she_in_if.sv
rtl/she_out_if.sv
rtl/she_div.sv
rtl/she_lane.sv
rtl/setpoint_hold_extrapolator_unit.sv
tb/sv/she_result_checker.sv
tb/sv/tb.sv
